// ----- sv/dtps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the depth-tested pixel store.
// Depends on nothing; used by the channel interfaces and the top level.
package dtps_pkg;

    // Fixed field widths of the channels
    localparam int ACT_W      = 2;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 16;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int CANVAS_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Defaults of the top-level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int COLOR_BITS_DEF = 24;

    // Register reset values
    localparam logic [CANVAS_W-1:0]       CANVAS_SIZE_RST = 9'd256;
    localparam logic [COLOR_W-1:0]        BACKGROUND_RST  = 24'h000000;
    localparam logic signed [DEPTH_W-1:0] FAR_DEPTH_RST   = 16'sh7FFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_DRAW_CLIP = 2'd0,
        ACT_DRAW_WRAP = 2'd1,
        ACT_CLEAR     = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH     = 2'd0,
        CFG_CANVAS_HEIGHT    = 2'd1,
        CFG_BACKGROUND_COLOR = 2'd2,
        CFG_FAR_DEPTH        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRAP,
        ST_WRAP_FIX,
        ST_LOOKUP,
        ST_CHECK,
        ST_CLEAR
    } state_t;

endpackage

// ----- sv/dtps_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the depth-tested pixel store:
// command, read response and register write. Depends on dtps_pkg.
interface dtps_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic [dtps_pkg::ACT_W-1:0]               action;
    logic signed [dtps_pkg::POS_W-1:0]        pos_x;
    logic signed [dtps_pkg::POS_W-1:0]        pos_y;
    logic signed [dtps_pkg::DEPTH_W-1:0]      draw_depth;
    logic [dtps_pkg::COLOR_W-1:0]             draw_color;
    logic [dtps_pkg::SIZE_W-1:0]              region_width;
    logic [dtps_pkg::SIZE_W-1:0]              region_height;

    modport source (
        output valid, action, pos_x, pos_y, draw_depth, draw_color,
               region_width, region_height,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, draw_depth, draw_color,
               region_width, region_height,
        output ready
    );
endinterface

interface dtps_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [dtps_pkg::COLOR_W-1:0]        pixel_color;
    logic signed [dtps_pkg::DEPTH_W-1:0] pixel_depth;
    logic                                pixel_valid;

    modport source (
        output valid, pixel_color, pixel_depth, pixel_valid,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, pixel_depth, pixel_valid,
        output ready
    );
endinterface

interface dtps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dtps_pkg::CFG_IDX_W-1:0]    index;
    logic [dtps_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- sv/depth_tested_pixel_store_top.sv -----
`timescale 1ns / 1ps
// Depth-tested pixel store: colour and depth memories with draw, clear and read.
// Depends on dtps_pkg and the channel interfaces in dtps_ifs.sv.
//
// Usage:
//   cmd carries one command per transfer: draw clipped, draw wrapped, clear a
//   rectangle or read one pixel. rsp carries one result per read command;
//   draws and clears give none. cfg writes the canvas size, the background
//   colour and the far depth; it is always ready and is meant to be written
//   only while no command is in flight.
//   After reset a clearing pass writes the reset background colour and far
//   depth into every memory entry, MAX_WIDTH * MAX_HEIGHT entries (65536 with
//   the defaults); cmd.ready stays low during that pass.
//   Draws are a read-modify-write and reads a read of one entry on the
//   single memory port, in a lookup step and a check step, with the next
//   command taken in the cycle the check completes. A wrapped draw whose
//   coordinates lie outside the canvas first runs a bit-serial remainder
//   unit and a fold step. A clipped draw outside the canvas is dropped as
//   it is taken. A clear writes one pixel per cycle over the clipped rectangle.
//   The read result sits in an output register; while it waits for rsp.ready
//   the next read holds in its check step, and draws and clears go on.
module depth_tested_pixel_store_top #(
    parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtps_pkg::DEPTH_BITS_DEF,
    parameter int COLOR_BITS = dtps_pkg::COLOR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dtps_cmd_if.sink   cmd,
    dtps_rsp_if.source rsp,
    dtps_cfg_if.sink   cfg
);

    localparam int PosW    = dtps_pkg::POS_W;
    localparam int SumW    = PosW + 2;
    localparam int DepthW  = dtps_pkg::DEPTH_W;
    localparam int ColorW  = dtps_pkg::COLOR_W;
    localparam int CanvasW = dtps_pkg::CANVAS_W;
    localparam int DepthN  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DepthN > 1) ? $clog2(DepthN) : 1;
    localparam int XBW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YBW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WBW     = $clog2(MAX_WIDTH + 1);
    localparam int HBW     = $clog2(MAX_HEIGHT + 1);
    localparam int CntW    = $clog2(PosW);

    function automatic int clamp_size(input logic [CanvasW-1:0] v, input int limit);
        int s;
        s = int'(v);
        if (s == 0) s = 1;
        if (s > limit) s = limit;
        return s;
    endfunction

    localparam logic [WBW-1:0] WidthRst =
        WBW'(clamp_size(dtps_pkg::CANVAS_SIZE_RST, MAX_WIDTH));
    localparam logic [HBW-1:0] HeightRst =
        HBW'(clamp_size(dtps_pkg::CANVAS_SIZE_RST, MAX_HEIGHT));
    localparam logic [COLOR_BITS-1:0] InitColor = COLOR_BITS'(dtps_pkg::BACKGROUND_RST);
    localparam logic signed [DEPTH_BITS-1:0] InitDepth = DEPTH_BITS'(dtps_pkg::FAR_DEPTH_RST);

    // ---------------- state ----------------
    dtps_pkg::state_t state_reg, state_next, accept_state;

    logic [AW-1:0]                 init_cnt_reg;
    logic [WBW-1:0]                width_reg;
    logic [HBW-1:0]                height_reg;
    logic [ColorW-1:0]             bg_reg;
    logic signed [DepthW-1:0]      far_reg;

    dtps_pkg::action_t             act_reg;
    logic [XBW-1:0]                x_reg;
    logic [YBW-1:0]                y_reg;
    logic                          inside_reg;
    logic signed [DEPTH_BITS-1:0]  depth_reg;
    logic [COLOR_BITS-1:0]         color_reg;

    logic [PosW-1:0]               mag_x_reg, mag_y_reg;
    logic                          neg_x_reg, neg_y_reg;
    logic [CntW-1:0]               bit_cnt_reg;

    logic [XBW-1:0]                cx_reg, x0_reg;
    logic [WBW-1:0]                x1_reg;
    logic [YBW-1:0]                cy_reg;
    logic [HBW-1:0]                y1_reg;

    logic [COLOR_BITS-1:0]         color_mem [DepthN];
    logic signed [DEPTH_BITS-1:0]  depth_mem [DepthN];
    logic [COLOR_BITS-1:0]         rd_color_reg;
    logic signed [DEPTH_BITS-1:0]  rd_depth_reg;

    logic                          rsp_valid_reg;
    logic [ColorW-1:0]             pix_color_reg;
    logic signed [DepthW-1:0]      pix_depth_reg;
    logic                          pix_valid_reg;

    // ---------------- command decode ----------------
    dtps_pkg::action_t             act_in;
    logic                          x_ok, y_ok;
    logic [PosW-1:0]               clr_x0, clr_y0;
    logic signed [SumW-1:0]        clr_xe, clr_ye, clr_x1, clr_y1, w_s, h_s;
    logic                          clr_empty;

    assign act_in = dtps_pkg::action_t'(cmd.action);
    assign x_ok   = !cmd.pos_x[PosW-1] && ({1'b0, cmd.pos_x} < (PosW+1)'(width_reg));
    assign y_ok   = !cmd.pos_y[PosW-1] && ({1'b0, cmd.pos_y} < (PosW+1)'(height_reg));

    assign w_s    = $signed(SumW'(width_reg));
    assign h_s    = $signed(SumW'(height_reg));
    assign clr_x0 = cmd.pos_x[PosW-1] ? '0 : cmd.pos_x;
    assign clr_y0 = cmd.pos_y[PosW-1] ? '0 : cmd.pos_y;
    assign clr_xe = SumW'(cmd.pos_x) + SumW'(cmd.region_width);
    assign clr_ye = SumW'(cmd.pos_y) + SumW'(cmd.region_height);
    assign clr_x1 = (clr_xe > w_s) ? w_s : clr_xe;
    assign clr_y1 = (clr_ye > h_s) ? h_s : clr_ye;
    assign clr_empty = (clr_x1 <= $signed({2'b00, clr_x0}))
                    || (clr_y1 <= $signed({2'b00, clr_y0}));

    always_comb
    begin
        case (act_in)
            dtps_pkg::ACT_DRAW_CLIP: accept_state = (x_ok && y_ok) ? dtps_pkg::ST_LOOKUP
                                                                   : dtps_pkg::ST_IDLE;
            dtps_pkg::ACT_DRAW_WRAP: accept_state = (x_ok && y_ok) ? dtps_pkg::ST_LOOKUP
                                                                   : dtps_pkg::ST_WRAP;
            dtps_pkg::ACT_CLEAR:     accept_state = clr_empty ? dtps_pkg::ST_IDLE
                                                              : dtps_pkg::ST_CLEAR;
            dtps_pkg::ACT_READ:      accept_state = dtps_pkg::ST_LOOKUP;
            default:                 accept_state = dtps_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    logic                          out_free, check_done, cmd_ready_int, cmd_fire;
    logic                          mem_we, rsp_load;
    logic [COLOR_BITS-1:0]         wr_color;
    logic signed [DEPTH_BITS-1:0]  wr_depth;

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        cmd_ready_int = 1'b0;
        check_done    = 1'b0;
        mem_we        = 1'b0;
        wr_color      = COLOR_BITS'(bg_reg);
        wr_depth      = DEPTH_BITS'(far_reg);
        case (state_reg)
            dtps_pkg::ST_INIT:
            begin
                mem_we   = 1'b1;
                wr_color = InitColor;
                wr_depth = InitDepth;
            end
            dtps_pkg::ST_IDLE:
            begin
                cmd_ready_int = 1'b1;
            end
            dtps_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            dtps_pkg::ST_CHECK:
            begin
                // a read holds here until the output register is free
                check_done    = (act_reg != dtps_pkg::ACT_READ) || out_free;
                cmd_ready_int = check_done;
                mem_we        = check_done && (act_reg != dtps_pkg::ACT_READ)
                             && inside_reg && (depth_reg <= rd_depth_reg);
                wr_color      = color_reg;
                wr_depth      = depth_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_fire = cmd.valid && cmd_ready_int;
    assign rsp_load = check_done && (act_reg == dtps_pkg::ACT_READ);

    // ---------------- loop ends ----------------
    logic init_last, cx_last, cy_last, wrap_last;

    assign init_last = (init_cnt_reg == AW'(DepthN - 1));
    assign cx_last   = ((XBW+1)'(cx_reg) + (XBW+1)'(1)) == (XBW+1)'(x1_reg);
    assign cy_last   = ((YBW+1)'(cy_reg) + (YBW+1)'(1)) == (YBW+1)'(y1_reg);
    assign wrap_last = (bit_cnt_reg == '0);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtps_pkg::ST_INIT:     if (init_last) state_next = dtps_pkg::ST_IDLE;
            dtps_pkg::ST_IDLE:     if (cmd_fire) state_next = accept_state;
            dtps_pkg::ST_WRAP:     if (wrap_last) state_next = dtps_pkg::ST_WRAP_FIX;
            dtps_pkg::ST_WRAP_FIX: state_next = dtps_pkg::ST_LOOKUP;
            dtps_pkg::ST_LOOKUP:   state_next = dtps_pkg::ST_CHECK;
            dtps_pkg::ST_CHECK:
            begin
                if (check_done)
                    state_next = cmd_fire ? accept_state : dtps_pkg::ST_IDLE;
            end
            dtps_pkg::ST_CLEAR:    if (cx_last && cy_last) state_next = dtps_pkg::ST_IDLE;
            default:               state_next = dtps_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtps_pkg::ST_INIT;
            init_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= WidthRst;
            height_reg    <= HeightRst;
            bg_reg        <= dtps_pkg::BACKGROUND_RST;
            far_reg       <= dtps_pkg::FAR_DEPTH_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dtps_pkg::ST_INIT)
                init_cnt_reg <= init_cnt_reg + AW'(1);
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                case (dtps_pkg::cfg_index_t'(cfg.index))
                    dtps_pkg::CFG_CANVAS_WIDTH:
                        width_reg <= WBW'(clamp_size(cfg.data[CanvasW-1:0], MAX_WIDTH));
                    dtps_pkg::CFG_CANVAS_HEIGHT:
                        height_reg <= HBW'(clamp_size(cfg.data[CanvasW-1:0], MAX_HEIGHT));
                    dtps_pkg::CFG_BACKGROUND_COLOR:
                        bg_reg <= cfg.data[ColorW-1:0];
                    dtps_pkg::CFG_FAR_DEPTH:
                        far_reg <= $signed(cfg.data[DepthW-1:0]);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    logic [XBW:0] rem_x_cand;
    logic [YBW:0] rem_y_cand;

    assign rem_x_cand = {x_reg, mag_x_reg[PosW-1]};
    assign rem_y_cand = {y_reg, mag_y_reg[PosW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            act_reg     <= act_in;
            depth_reg   <= DEPTH_BITS'(cmd.draw_depth);
            color_reg   <= COLOR_BITS'(cmd.draw_color);
            inside_reg  <= (act_in == dtps_pkg::ACT_DRAW_WRAP) || (x_ok && y_ok);
            mag_x_reg   <= cmd.pos_x[PosW-1] ? PosW'(-cmd.pos_x) : cmd.pos_x;
            mag_y_reg   <= cmd.pos_y[PosW-1] ? PosW'(-cmd.pos_y) : cmd.pos_y;
            neg_x_reg   <= cmd.pos_x[PosW-1];
            neg_y_reg   <= cmd.pos_y[PosW-1];
            bit_cnt_reg <= CntW'(PosW - 1);
            // the remainder unit builds the reduced coordinate in x_reg / y_reg
            if (accept_state == dtps_pkg::ST_WRAP)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else
            begin
                x_reg <= XBW'(cmd.pos_x);
                y_reg <= YBW'(cmd.pos_y);
            end
            cx_reg <= XBW'(clr_x0);
            x0_reg <= XBW'(clr_x0);
            x1_reg <= WBW'(clr_x1);
            cy_reg <= YBW'(clr_y0);
            y1_reg <= HBW'(clr_y1);
        end
        else
        begin
            case (state_reg)
                dtps_pkg::ST_WRAP:
                begin
                    // one quotient bit per cycle, keep only the remainder
                    x_reg <= (rem_x_cand >= (XBW+1)'(width_reg))
                           ? XBW'(rem_x_cand - (XBW+1)'(width_reg)) : XBW'(rem_x_cand);
                    y_reg <= (rem_y_cand >= (YBW+1)'(height_reg))
                           ? YBW'(rem_y_cand - (YBW+1)'(height_reg)) : YBW'(rem_y_cand);
                    mag_x_reg   <= {mag_x_reg[PosW-2:0], 1'b0};
                    mag_y_reg   <= {mag_y_reg[PosW-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - CntW'(1);
                end
                dtps_pkg::ST_WRAP_FIX:
                begin
                    // negative input: fold a nonzero remainder back to size - r
                    if (neg_x_reg && (x_reg != '0))
                        x_reg <= XBW'((XBW+1)'(width_reg) - (XBW+1)'(x_reg));
                    if (neg_y_reg && (y_reg != '0))
                        y_reg <= YBW'((YBW+1)'(height_reg) - (YBW+1)'(y_reg));
                end
                dtps_pkg::ST_CLEAR:
                begin
                    if (cx_last)
                    begin
                        cx_reg <= x0_reg;
                        cy_reg <= cy_reg + YBW'(1);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + XBW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (rsp_load)
        begin
            pix_color_reg <= inside_reg ? ColorW'(rd_color_reg) : '0;
            pix_depth_reg <= inside_reg ? DepthW'(rd_depth_reg) : '0;
            pix_valid_reg <= inside_reg;
        end
    end

    // ---------------- memories ----------------
    logic [XBW-1:0] addr_x;
    logic [YBW-1:0] addr_y;
    logic [AW-1:0]  mem_addr;

    assign addr_x = (state_reg == dtps_pkg::ST_CLEAR) ? cx_reg : x_reg;
    assign addr_y = (state_reg == dtps_pkg::ST_CLEAR) ? cy_reg : y_reg;
    assign mem_addr = (state_reg == dtps_pkg::ST_INIT) ? init_cnt_reg
                    : AW'(32'(addr_y) * 32'(MAX_WIDTH) + 32'(addr_x));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[mem_addr] <= wr_color;
            depth_mem[mem_addr] <= wr_depth;
        end
        rd_color_reg <= color_mem[mem_addr];
        rd_depth_reg <= depth_mem[mem_addr];
    end

    // ---------------- ports ----------------
    assign cmd.ready       = cmd_ready_int;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pixel_color = pix_color_reg;
    assign rsp.pixel_depth = pix_depth_reg;
    assign rsp.pixel_valid = pix_valid_reg;

    // ---------------- assertions ----------------
    a_clear_cursor_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtps_pkg::ST_CLEAR
        |-> ((XBW+1)'(cx_reg) < (XBW+1)'(x1_reg)) && ((YBW+1)'(cy_reg) < (YBW+1)'(y1_reg)))
        else $error("clear cursor left its region");

    a_wrap_result_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtps_pkg::ST_WRAP_FIX
        |=> ((XBW+1)'(x_reg) < (XBW+1)'(width_reg)) && ((YBW+1)'(y_reg) < (YBW+1)'(height_reg)))
        else $error("wrapped coordinate outside canvas");

    a_no_cmd_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtps_pkg::ST_INIT |-> !cmd.ready)
        else $error("command taken during clearing pass");

    a_result_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> !($past(rsp_load)))
        else $error("read result overwritten before transfer");

endmodule

// ----- dv/pixel_store_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the depth-tested pixel store: mirrors the colour and depth
// memories and the canvas registers, and checks every read result in order.
// Depends on dtps_pkg and the channel interfaces in dtps_ifs.sv.
module pixel_store_checker (
    input  logic clk,
    input  logic rst_n,
    dtps_cmd_if  cmd,
    dtps_rsp_if  rsp,
    dtps_cfg_if  cfg,
    output int   mismatches,
    output int   reads_outstanding
);
    import dtps_pkg::*;

    localparam int COLS  = MAX_WIDTH_DEF;
    localparam int ROWS  = MAX_HEIGHT_DEF;
    localparam int CELLS = COLS * ROWS;

    typedef struct {
        logic [COLOR_W-1:0]        color;
        logic signed [DEPTH_W-1:0] depth;
        logic                      on_canvas;
    } pixel_read_t;

    logic [COLOR_W-1:0]        color_mem [CELLS];
    logic signed [DEPTH_W-1:0] depth_mem [CELLS];
    logic [CANVAS_W-1:0]       width_reg;
    logic [CANVAS_W-1:0]       height_reg;
    logic [COLOR_W-1:0]        background_reg;
    logic signed [DEPTH_W-1:0] far_reg;
    pixel_read_t               pending_reads [$];
    int                        lines_printed;

    // Zero acts as one, anything above the memory size as the memory size
    function automatic int used_size(logic [CANVAS_W-1:0] reg_value, int limit);
        if (reg_value == '0)
            return 1;
        if (int'(reg_value) > limit)
            return limit;
        return int'(reg_value);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (lines_printed < 40)
        begin
            $display("%0t: mismatch: %s", $time, msg);
            lines_printed++;
        end
    endtask

    function automatic void fill_stores();
        for (int i = 0; i < CELLS; i++)
        begin
            color_mem[i] = background_reg;
            depth_mem[i] = far_reg;
        end
    endfunction

    function automatic void draw_pixel(logic wrapped, int x, int y,
                                       logic signed [DEPTH_W-1:0] depth,
                                       logic [COLOR_W-1:0] color);
        int w;
        int h;
        int idx;
        w = used_size(width_reg, COLS);
        h = used_size(height_reg, ROWS);
        if (wrapped)
        begin
            // true modulo: negative exact multiples land on 0
            x = x % w;
            y = y % h;
            if (x < 0)
                x += w;
            if (y < 0)
                y += h;
        end
        if (x < 0 || y < 0 || x >= w || y >= h)
            return;
        idx = y * COLS + x;
        // equal depth wins, so the later draw replaces the earlier one
        if (depth <= depth_mem[idx])
        begin
            depth_mem[idx] = depth;
            color_mem[idx] = color;
        end
    endfunction

    function automatic void clear_region(int x, int y, int cols, int rows);
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = x + cols;
        y1 = y + rows;
        if (x1 > used_size(width_reg, COLS))
            x1 = used_size(width_reg, COLS);
        if (y1 > used_size(height_reg, ROWS))
            y1 = used_size(height_reg, ROWS);
        for (int j = y0; j < y1; j++)
        begin
            for (int i = x0; i < x1; i++)
            begin
                color_mem[j * COLS + i] = background_reg;
                depth_mem[j * COLS + i] = far_reg;
            end
        end
    endfunction

    function automatic pixel_read_t read_pixel(int x, int y);
        pixel_read_t r;
        r.color     = '0;
        r.depth     = '0;
        r.on_canvas = 1'b0;
        if (x >= 0 && y >= 0 && x < used_size(width_reg, COLS)
            && y < used_size(height_reg, ROWS))
        begin
            r.color     = color_mem[y * COLS + x];
            r.depth     = depth_mem[y * COLS + x];
            r.on_canvas = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_read_t want;
        if (!rst_n)
        begin
            width_reg      = CANVAS_SIZE_RST;
            height_reg     = CANVAS_SIZE_RST;
            background_reg = BACKGROUND_RST;
            far_reg        = FAR_DEPTH_RST;
            fill_stores();
            pending_reads.delete();
            mismatches     = 0;
            lines_printed  = 0;
            reads_outstanding <= 0;
        end
        else
        begin
            // retire results first: a result always belongs to an earlier read
            if (rsp.valid && rsp.ready)
            begin
                if (pending_reads.size() == 0)
                    report_mismatch("read result with no read waiting");
                else
                begin
                    want = pending_reads.pop_front();
                    if (rsp.pixel_color !== want.color)
                        report_mismatch($sformatf("pixel_color %h, want %h",
                                                  rsp.pixel_color, want.color));
                    if (rsp.pixel_depth !== want.depth)
                        report_mismatch($sformatf("pixel_depth %0d, want %0d",
                                                  rsp.pixel_depth, want.depth));
                    if (rsp.pixel_valid !== want.on_canvas)
                        report_mismatch($sformatf("pixel_valid %b, want %b",
                                                  rsp.pixel_valid, want.on_canvas));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_CANVAS_WIDTH:     width_reg      = cfg.data[CANVAS_W-1:0];
                    CFG_CANVAS_HEIGHT:    height_reg     = cfg.data[CANVAS_W-1:0];
                    CFG_BACKGROUND_COLOR: background_reg = cfg.data[COLOR_W-1:0];
                    CFG_FAR_DEPTH:        far_reg        = cfg.data[DEPTH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                case (action_t'(cmd.action))
                    ACT_DRAW_CLIP:
                        draw_pixel(1'b0, int'(cmd.pos_x), int'(cmd.pos_y),
                                   cmd.draw_depth, cmd.draw_color);
                    ACT_DRAW_WRAP:
                        draw_pixel(1'b1, int'(cmd.pos_x), int'(cmd.pos_y),
                                   cmd.draw_depth, cmd.draw_color);
                    ACT_CLEAR:
                        clear_region(int'(cmd.pos_x), int'(cmd.pos_y),
                                     int'(cmd.region_width), int'(cmd.region_height));
                    ACT_READ:
                        pending_reads.push_back(read_pixel(int'(cmd.pos_x),
                                                           int'(cmd.pos_y)));
                    default:
                    begin
                    end
                endcase
            end
            reads_outstanding <= pending_reads.size();
        end
    end

endmodule

// ----- dv/tb_depth_tested_pixel_store_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the depth-tested pixel store: directed corner
// cases, then random draw/clear/read traffic over several canvas settings.
// Depends on dtps_pkg, dtps_ifs.sv, pixel_store_checker and the block itself.
module tb_depth_tested_pixel_store_top;
    import dtps_pkg::*;

    typedef struct {
        action_t                   act;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0]        color;
        logic [SIZE_W-1:0]         cols;
        logic [SIZE_W-1:0]         rows;
    } pixel_cmd_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    bit                        steady;
    int                        mismatches;
    int                        reads_outstanding;
    int                        canvas_cols;
    int                        canvas_rows;
    logic signed [DEPTH_W-1:0] depth_center;

    dtps_cmd_if cmd_ch ();
    dtps_rsp_if rsp_ch ();
    dtps_cfg_if cfg_ch ();

    depth_tested_pixel_store_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    pixel_store_checker store_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd_ch),
        .rsp               (rsp_ch),
        .cfg               (cfg_ch),
        .mismatches        (mismatches),
        .reads_outstanding (reads_outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the response side at random, except in the steady stretch
    always @(posedge clk)
        rsp_ch.ready <= steady || ($urandom_range(99) >= 14);

    function automatic pixel_cmd_t noise_cmd();
        pixel_cmd_t c;
        c.act   = action_t'($urandom_range(3));
        c.x     = POS_W'($urandom);
        c.y     = POS_W'($urandom);
        c.depth = DEPTH_W'($urandom);
        c.color = COLOR_W'($urandom);
        c.cols  = SIZE_W'($urandom);
        c.rows  = SIZE_W'($urandom);
        return c;
    endfunction

    function automatic pixel_cmd_t draw_cmd(action_t act, int x, int y, int depth,
                                            int color);
        pixel_cmd_t c;
        c       = noise_cmd();
        c.act   = act;
        c.x     = POS_W'(x);
        c.y     = POS_W'(y);
        c.depth = DEPTH_W'(depth);
        c.color = COLOR_W'(color);
        return c;
    endfunction

    function automatic pixel_cmd_t read_cmd(int x, int y);
        pixel_cmd_t c;
        c     = noise_cmd();
        c.act = ACT_READ;
        c.x   = POS_W'(x);
        c.y   = POS_W'(y);
        return c;
    endfunction

    function automatic pixel_cmd_t clear_cmd(int x, int y, int cols, int rows);
        pixel_cmd_t c;
        c      = noise_cmd();
        c.act  = ACT_CLEAR;
        c.x    = POS_W'(x);
        c.y    = POS_W'(y);
        c.cols = SIZE_W'(cols);
        c.rows = SIZE_W'(rows);
        return c;
    endfunction

    // Mostly a small hot corner so draws and reads hit the same pixels
    function automatic logic signed [POS_W-1:0] pick_coord(int size);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 50)
            v = int'($urandom_range(((size < 8) ? size : 8) - 1, 0));
        else if (r < 80)
            v = int'($urandom_range(size - 1, 0));
        else
        begin
            case ($urandom_range(4))
                0:       v = -1;
                1:       v = size;
                2:       v = size - 1;
                3:       v = -32768;
                default: v = int'($urandom);
            endcase
        end
        return POS_W'(v);
    endfunction

    function automatic logic signed [DEPTH_W-1:0] pick_depth();
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 6)
            v = int'(depth_center) + int'($urandom_range(40)) - 20;
        else if (r == 6)
            v = -32768;
        else if (r == 7)
            v = 32767;
        else
            v = int'($urandom);
        return DEPTH_W'(v);
    endfunction

    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t c;
        int         r;
        c = noise_cmd();
        r = $urandom_range(99);
        if (r < 40)
        begin
            c.act = ACT_DRAW_CLIP;
            c.x   = pick_coord(canvas_cols);
            c.y   = pick_coord(canvas_rows);
        end
        else if (r < 55)
        begin
            c.act = ACT_DRAW_WRAP;
            if ($urandom_range(1) == 0)
            begin
                c.x = pick_coord(canvas_cols);
                c.y = pick_coord(canvas_rows);
            end
        end
        else if (r < 90)
        begin
            c.act = ACT_READ;
            c.x   = pick_coord(canvas_cols);
            c.y   = pick_coord(canvas_rows);
        end
        else if (r < 98)
        begin
            c.act = ACT_CLEAR;
            c.x   = pick_coord(canvas_cols);
            c.y   = pick_coord(canvas_rows);
            // keep clears short on a big canvas, full-range sizes otherwise
            if (canvas_cols * canvas_rows > 4096)
            begin
                case ($urandom_range(3))
                    0, 1:
                    begin
                        c.cols = SIZE_W'($urandom_range(12));
                        c.rows = SIZE_W'($urandom_range(12));
                    end
                    2:       c.rows = SIZE_W'($urandom_range(2));
                    default: c.cols = SIZE_W'($urandom_range(2));
                endcase
            end
        end
        else if (c.act == ACT_CLEAR)
            c.rows = SIZE_W'($urandom_range(2));
        if (c.act == ACT_DRAW_CLIP || c.act == ACT_DRAW_WRAP)
        begin
            if ($urandom_range(9) < 8)
                c.depth = pick_depth();
        end
        return c;
    endfunction

    // Leaves valid high so the next transfer can follow back to back
    task automatic issue(pixel_cmd_t c);
        while (!steady && $urandom_range(99) < 14)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.action        <= c.act;
        cmd_ch.pos_x         <= c.x;
        cmd_ch.pos_y         <= c.y;
        cmd_ch.draw_depth    <= c.depth;
        cmd_ch.draw_color    <= c.color;
        cmd_ch.region_width  <= c.cols;
        cmd_ch.region_height <= c.rows;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic wait_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (reads_outstanding != 0)
            @(posedge clk);
    endtask

    // A trailing read cannot return before every earlier command is done
    task automatic drain();
        issue(read_cmd(0, 0));
        wait_results();
        repeat (32) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic set_canvas(int cols9, int rows9, logic [COLOR_W-1:0] bg,
                              logic signed [DEPTH_W-1:0] far);
        write_reg(CFG_CANVAS_WIDTH, {15'($urandom), CANVAS_W'(cols9)});
        write_reg(CFG_CANVAS_HEIGHT, {15'($urandom), CANVAS_W'(rows9)});
        write_reg(CFG_BACKGROUND_COLOR, bg);
        write_reg(CFG_FAR_DEPTH, {8'($urandom), far});
        cfg_ch.valid <= 1'b0;
        canvas_cols  = (cols9 == 0) ? 1 : ((cols9 > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cols9);
        canvas_rows  = (rows9 == 0) ? 1 : ((rows9 > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : rows9);
        depth_center = far;
    endtask

    task automatic run_random(int count, int steady_from, int steady_to, int pause_at);
        for (int i = 0; i < count; i++)
        begin
            steady <= (i >= steady_from && i < steady_to);
            if (i == pause_at)
                wait_results();
            issue(random_cmd());
        end
        steady <= 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        steady               = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.action        = ACT_READ;
        cmd_ch.pos_x         = '0;
        cmd_ch.pos_y         = '0;
        cmd_ch.draw_depth    = '0;
        cmd_ch.draw_color    = '0;
        cmd_ch.region_width  = '0;
        cmd_ch.region_height = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_CANVAS_WIDTH;
        cfg_ch.data          = '0;
        rsp_ch.ready         = 1'b0;
        canvas_cols          = MAX_WIDTH_DEF;
        canvas_rows          = MAX_HEIGHT_DEF;
        depth_center         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, depth test with win, tie and loss
        issue(read_cmd(0, 0));
        issue(draw_cmd(ACT_DRAW_CLIP, 0, 0, 100, 24'h123456));
        issue(read_cmd(0, 0));
        issue(draw_cmd(ACT_DRAW_CLIP, 0, 0, 100, 24'hABCDEF));
        issue(draw_cmd(ACT_DRAW_CLIP, 0, 0, 101, 24'h111111));
        issue(read_cmd(0, 0));
        issue(draw_cmd(ACT_DRAW_CLIP, 255, 255, -32768, 24'hFFFFFF));
        // Clipped draws and reads outside the canvas
        issue(draw_cmd(ACT_DRAW_CLIP, -1, 0, -32768, 24'h0000FF));
        issue(draw_cmd(ACT_DRAW_CLIP, 256, 5, -32768, 24'h00FF00));
        issue(draw_cmd(ACT_DRAW_CLIP, 32767, -32768, -32768, 24'hFF0000));
        issue(read_cmd(256, 5));
        issue(read_cmd(-32768, 32767));
        issue(read_cmd(255, 255));
        // Wrapped draws, negative exact multiples included
        issue(draw_cmd(ACT_DRAW_WRAP, -256, -512, -5, 24'h000001));
        issue(draw_cmd(ACT_DRAW_WRAP, 32767, -1, -32768, 24'h800000));
        issue(read_cmd(0, 0));
        issue(read_cmd(255, 255));
        // Clears hanging off the canvas and empty clears
        issue(clear_cmd(250, 250, 65535, 65535));
        issue(clear_cmd(-32768, -32768, 0, 0));
        issue(clear_cmd(3, 3, 0, 5));
        issue(read_cmd(255, 255));
        issue(read_cmd(250, 250));
        issue(read_cmd(249, 250));
        issue(read_cmd(0, 0));
        drain();

        // Smallest canvas, extreme registers
        set_canvas(0, 0, 24'hFFFFFF, 16'sh8000);
        issue(clear_cmd(-32768, -32768, 65535, 65535));
        issue(read_cmd(0, 0));
        issue(read_cmd(1, 0));
        issue(draw_cmd(ACT_DRAW_WRAP, -1, -1, -32768, 24'h5A5A5A));
        issue(read_cmd(0, 0));
        run_random(140, -1, -1, -1);
        drain();

        // Oversized canvas acts as the full memory; full clear first
        set_canvas(511, 300, 24'($urandom), 16'sh7FFF);
        issue(clear_cmd(0, 0, 256, 256));
        run_random(300, 40, 200, 250);
        drain();

        // Shrunk canvas keeps earlier contents
        set_canvas(17, 9, 24'($urandom), 16'($urandom));
        run_random(250, -1, -1, -1);
        drain();

        set_canvas(1, 256, 24'($urandom), 16'($urandom));
        run_random(150, -1, -1, -1);
        drain();

        set_canvas(256, 1, 24'($urandom), 16'($urandom));
        run_random(150, -1, -1, -1);
        drain();

        set_canvas(100, 37, 24'h000000, 16'sh7FFF);
        run_random(110, -1, -1, -1);
        drain();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- depth_tested_pixel_store_top.f -----
sv/dtps_pkg.sv
sv/dtps_ifs.sv
sv/depth_tested_pixel_store_top.sv
dv/pixel_store_checker.sv
dv/tb_depth_tested_pixel_store_top.sv
